// ===== design/msa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_pkg: shared types and constants of the mesh surface area accumulator
// Item layouts, derived widths, datapath op codes and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package msa_pkg;

	// field widths of the items
	localparam int COORD_W = 16;
	localparam int SUM_W   = 48;

	// derived datapath widths
	localparam int DIFF_W = COORD_W + 1;            // edge vector component
	localparam int MAG_W  = 2 * COORD_W + 1;        // |cross product component|
	localparam int HALF_W = DIFF_W;                 // low half of a magnitude
	localparam int HIGH_W = MAG_W - HALF_W;         // high half of a magnitude
	localparam int OPND_W = DIFF_W + 1;             // signed multiplier operand
	localparam int PROD_W = 2 * OPND_W;             // multiplier product
	localparam int SQ_W   = 2 * MAG_W + 2;          // squared norm
	localparam int ROOT_W = SQ_W / 2;               // integer square root
	localparam int REM_W  = ROOT_W + 2;             // root remainder
	localparam int ACC_W  = ((ROOT_W > SUM_W) ? ROOT_W : SUM_W) + 1;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// one triangle
	typedef struct packed {
		logic signed [COORD_W-1:0] v0_x;
		logic signed [COORD_W-1:0] v0_y;
		logic signed [COORD_W-1:0] v0_z;
		logic signed [COORD_W-1:0] v1_x;
		logic signed [COORD_W-1:0] v1_y;
		logic signed [COORD_W-1:0] v1_z;
		logic signed [COORD_W-1:0] v2_x;
		logic signed [COORD_W-1:0] v2_y;
		logic signed [COORD_W-1:0] v2_z;
		logic                      last_triangle;
	} tri_item_t;

	// one mesh result
	typedef struct packed {
		logic [SUM_W-1:0] twice_area_total;
		logic             saturated;
	} area_item_t;

	// multiply/accumulate micro-ops, five per axis of the normal
	typedef enum logic [2:0] {
		OP_CROSS_LOAD = 3'd0,
		OP_CROSS_SUB  = 3'd1,
		OP_SQ_HH      = 3'd2,
		OP_SQ_HL      = 3'd3,
		OP_SQ_LL      = 3'd4
	} op_t;

	// normal component being worked on
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// controller to datapath
	typedef struct packed {
		logic  capture;    // latch edge vectors, clear root state
		logic  mul;        // register product of selected operands
		logic  apply;      // fold registered product per op
		op_t   op;
		axis_t axis;
		logic  root_step;  // one root bit
		logic  accum;      // add root to the running sum
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;        // current triangle ends the mesh
		logic out_busy;    // result register held and not taken this cycle
	} sts_t;

endpackage
`default_nettype wire

// ===== design/msa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_ctrl: sequencer of the mesh surface area accumulator
// Walks one triangle through the multiply/accumulate steps, the bit-serial
// square root and the final accumulate, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module msa_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  msa_pkg::sts_t  sts,
	output msa_pkg::cmd_t  cmd
);

	localparam int RCNT_W = $clog2(msa_pkg::ROOT_W);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CALC  = 4'b0010,
		ST_ROOT  = 4'b0100,
		ST_ACCUM = 4'b1000
	} state_t;

	state_t             state_q;
	logic               phase_q;
	msa_pkg::op_t       op_q;
	msa_pkg::axis_t     axis_q;
	logic [RCNT_W-1:0]  rcnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.axis      = axis_q;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.mul       = (state_q == ST_CALC) && !phase_q;
		cmd.apply     = (state_q == ST_CALC) && phase_q;
		cmd.root_step = (state_q == ST_ROOT);
		cmd.accum     = (state_q == ST_ACCUM) && !(sts.last && sts.out_busy);
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			op_q    <= msa_pkg::OP_CROSS_LOAD;
			axis_q  <= msa_pkg::AXIS_X;
			rcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
						phase_q <= 1'b0;
						op_q    <= msa_pkg::OP_CROSS_LOAD;
						axis_q  <= msa_pkg::AXIS_X;
					end
				end
				ST_CALC: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						case (op_q)
							msa_pkg::OP_CROSS_LOAD: op_q <= msa_pkg::OP_CROSS_SUB;
							msa_pkg::OP_CROSS_SUB:  op_q <= msa_pkg::OP_SQ_HH;
							msa_pkg::OP_SQ_HH:      op_q <= msa_pkg::OP_SQ_HL;
							msa_pkg::OP_SQ_HL:      op_q <= msa_pkg::OP_SQ_LL;
							default: begin
								op_q <= msa_pkg::OP_CROSS_LOAD;
								case (axis_q)
									msa_pkg::AXIS_X: axis_q <= msa_pkg::AXIS_Y;
									msa_pkg::AXIS_Y: axis_q <= msa_pkg::AXIS_Z;
									default: begin
										axis_q  <= msa_pkg::AXIS_X;
										state_q <= ST_ROOT;
										rcnt_q  <= RCNT_W'(msa_pkg::ROOT_W - 1);
									end
								endcase
							end
						endcase
					end
				end
				ST_ROOT: begin
					rcnt_q <= rcnt_q - 1'b1;
					if (rcnt_q == '0) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					// a final triangle waits until the result register is free
					if (!(sts.last && sts.out_busy)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/msa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_datapath: arithmetic of the mesh surface area accumulator
// Edge vectors, one shared signed multiplier, squared norm accumulation,
// restoring square root, saturating running sum and the result register.
// ----------------------------------------------------------------------------
module msa_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  msa_pkg::tri_item_t  in_data,
	input  msa_pkg::cmd_t       cmd,
	output msa_pkg::sts_t       sts,
	output logic                out_valid,
	input  wire                 out_ready,
	output msa_pkg::area_item_t out_data
);

	localparam int DW = msa_pkg::DIFF_W;
	localparam int CW = msa_pkg::COORD_W;
	localparam int OW = msa_pkg::OPND_W;
	localparam int PW = msa_pkg::PROD_W;
	localparam int HW = msa_pkg::HALF_W;
	localparam int GW = msa_pkg::HIGH_W;
	localparam int MW = msa_pkg::MAG_W;
	localparam int QW = msa_pkg::SQ_W;
	localparam int RW = msa_pkg::ROOT_W;
	localparam int EW = msa_pkg::REM_W;
	localparam int SW = msa_pkg::SUM_W;
	localparam int AW = msa_pkg::ACC_W;

	logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic                 last_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] cross_q;
	logic [MW-1:0]        mag_q;
	logic [QW-1:0]        sq_q;
	logic [EW-1:0]        rem_q;
	logic [RW-1:0]        root_q;
	logic [SW-1:0]        sum_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	msa_pkg::area_item_t  out_q;

	// sign-extended difference of two coordinates
	function automatic logic signed [DW-1:0] edge_diff(
		input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] o
	);
		edge_diff = $signed({p[CW-1], p}) - $signed({o[CW-1], o});
	endfunction

	// operand select for the shared multiplier
	logic signed [OW-1:0] opa, opb;
	logic signed [OW-1:0] hi_op, lo_op;
	logic signed [DW-1:0] d0a, d0b, d1a, d1b;

	assign hi_op = $signed({{(OW-GW){1'b0}}, mag_q[MW-1:HW]});
	assign lo_op = $signed({{(OW-HW){1'b0}}, mag_q[HW-1:0]});

	always_comb begin
		case (cmd.axis)
			msa_pkg::AXIS_X: begin
				d0a = ay_q; d0b = bz_q; d1a = az_q; d1b = by_q;
			end
			msa_pkg::AXIS_Y: begin
				d0a = az_q; d0b = bx_q; d1a = ax_q; d1b = bz_q;
			end
			default: begin
				d0a = ax_q; d0b = by_q; d1a = ay_q; d1b = bx_q;
			end
		endcase
		case (cmd.op)
			msa_pkg::OP_CROSS_LOAD: begin
				opa = $signed({d0a[DW-1], d0a});
				opb = $signed({d0b[DW-1], d0b});
			end
			msa_pkg::OP_CROSS_SUB: begin
				opa = $signed({d1a[DW-1], d1a});
				opb = $signed({d1b[DW-1], d1b});
			end
			msa_pkg::OP_SQ_HH: begin
				opa = hi_op; opb = hi_op;
			end
			msa_pkg::OP_SQ_HL: begin
				opa = hi_op; opb = lo_op;
			end
			default: begin
				opa = lo_op; opb = lo_op;
			end
		endcase
	end

	// cross component and its magnitude
	logic signed [PW-1:0] cdiff, cneg;
	assign cdiff = cross_q - prod_q;
	assign cneg  = prod_q - cross_q;

	// partial square term, shifted into place
	logic [2*HW-1:0] prod_u;
	logic [QW-1:0]   sq_term;
	assign prod_u = prod_q[2*HW-1:0];

	always_comb begin
		case (cmd.op)
			msa_pkg::OP_SQ_HH: sq_term = QW'(prod_u) << (2 * HW);
			msa_pkg::OP_SQ_HL: sq_term = QW'(prod_u) << (HW + 1);
			default:           sq_term = QW'(prod_u);
		endcase
	end

	// one root bit per step
	logic [EW-1:0] rem_base, rem_trial;
	logic          root_fit;
	assign rem_base  = {rem_q[EW-3:0], sq_q[QW-1 -: 2]};
	assign rem_trial = {root_q, 2'b01};
	assign root_fit  = (rem_base >= rem_trial);

	// saturating sum
	logic [AW-1:0] sum_ext;
	logic          sum_sat;
	logic [SW-1:0] sum_new;
	logic          ovf_new;
	assign sum_ext = AW'(sum_q) + AW'(root_q);
	assign sum_sat = (sum_ext > AW'(msa_pkg::SUM_MAX));
	assign sum_new = sum_sat ? msa_pkg::SUM_MAX : sum_ext[SW-1:0];
	assign ovf_new = ovf_q | sum_sat;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q   <= edge_diff(in_data.v1_x, in_data.v0_x);
			ay_q   <= edge_diff(in_data.v1_y, in_data.v0_y);
			az_q   <= edge_diff(in_data.v1_z, in_data.v0_z);
			bx_q   <= edge_diff(in_data.v2_x, in_data.v0_x);
			by_q   <= edge_diff(in_data.v2_y, in_data.v0_y);
			bz_q   <= edge_diff(in_data.v2_z, in_data.v0_z);
			last_q <= in_data.last_triangle;
			sq_q   <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= opa * opb;
		end
		if (cmd.apply) begin
			case (cmd.op)
				msa_pkg::OP_CROSS_LOAD: cross_q <= prod_q;
				msa_pkg::OP_CROSS_SUB:  mag_q   <= cdiff[PW-1] ? cneg[MW-1:0] : cdiff[MW-1:0];
				default:                sq_q    <= sq_q + sq_term;
			endcase
		end
		if (cmd.root_step) begin
			sq_q <= sq_q << 2;
			if (root_fit) begin
				rem_q  <= rem_base - rem_trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_base;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.accum && last_q) begin
			out_q.twice_area_total <= sum_new;
			out_q.saturated        <= ovf_new;
		end
	end

	// mesh state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				if (last_q) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_new;
					ovf_q <= ovf_new;
				end
			end
			if (cmd.accum && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule
`default_nettype wire

// ===== design/mesh_surface_area_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_surface_area_accumulator: streaming triangle mesh surface area
// Sums floor(|e1 x e2|) over the triangles of a mesh and reports the total,
// which is the mesh area in half-square units, with a sticky saturation flag.
//
// Input channel (in_valid/in_ready/in_data): one triangle per item, with
// last_triangle marking the end of a mesh. Output channel (out_valid/
// out_ready/out_data): one item per mesh, issued after its last triangle.
// Each triangle passes through the multiply/fold steps on the one shared
// multiplier, then the square root at one bit per cycle over 2*COORD_W + 2
// bits, then the sum update; in_ready is high only between triangles. The
// result is loaded into the output register by the sum update of the mesh's
// last triangle.
// The result sits in an output register: new triangles are accepted while it
// waits, and only the next mesh's last triangle holds in its final step until
// the pending result is taken.
// Reset clears the running sum, the saturation flag and the output valid.
// ----------------------------------------------------------------------------
module mesh_surface_area_accumulator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  msa_pkg::tri_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output msa_pkg::area_item_t out_data
);

	msa_pkg::cmd_t cmd;
	msa_pkg::sts_t sts;

	msa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== test/mesh_surface_area_accumulator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_surface_area_accumulator_test: self-checking mesh area testbench
// Streams triangles into the accumulator and works out each mesh total on its
// own side: exact cross product, truncated root of the squared norm, and a
// saturating sum. Every mesh total is checked field by field, in order.
// Covers shaped and degenerate triangles, random meshes, idle gaps on both
// channels, a long output stall and a long mesh of the largest triangles.
// ----------------------------------------------------------------------------
module mesh_surface_area_accumulator_test;

	localparam int CLK_HALF    = 2;
	localparam int QUIET_LIMIT = 5000;  // cycles with no item moving
	localparam int SETTLE      = 80;    // a little over the result latency

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	msa_pkg::tri_item_t   in_data;
	logic                 out_valid;
	logic                 out_ready;
	msa_pkg::area_item_t  out_data;

	// running mesh total as the block should hold it
	logic [msa_pkg::SUM_W-1:0] mesh_tally;
	logic                      mesh_clamped;
	msa_pkg::area_item_t       pending_totals [$];

	int errors;
	int idle_cycles;
	int hold_req;
	int hold_left;
	bit steady;

	mesh_surface_area_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// twice the triangle area: floor(|e1 x e2|), norm squared formed exactly
	function automatic logic [63:0] doubled_area(input msa_pkg::tri_item_t t);
		longint ax, ay, az, bx, by, bz, nx, ny, nz;
		logic [127:0] norm_sq;
		logic [127:0] cand;
		logic [63:0]  root;
		ax = longint'($signed(t.v1_x)) - longint'($signed(t.v0_x));
		ay = longint'($signed(t.v1_y)) - longint'($signed(t.v0_y));
		az = longint'($signed(t.v1_z)) - longint'($signed(t.v0_z));
		bx = longint'($signed(t.v2_x)) - longint'($signed(t.v0_x));
		by = longint'($signed(t.v2_y)) - longint'($signed(t.v0_y));
		bz = longint'($signed(t.v2_z)) - longint'($signed(t.v0_z));
		nx = ay * bz - az * by;
		ny = az * bx - ax * bz;
		nz = ax * by - ay * bx;
		if (nx < 0) nx = -nx;
		if (ny < 0) ny = -ny;
		if (nz < 0) nz = -nz;
		norm_sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
		// bitwise integer square root, truncating
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = {64'd0, root | (64'd1 << b)};
			if (cand * cand <= norm_sq) root = cand[63:0];
		end
		return root;
	endfunction

	function automatic msa_pkg::tri_item_t make_tri(input int x0, input int y0, input int z0,
			input int x1, input int y1, input int z1,
			input int x2, input int y2, input int z2, input bit last);
		return {16'(x0), 16'(y0), 16'(z0), 16'(x1), 16'(y1), 16'(z1),
			16'(x2), 16'(y2), 16'(z2), last};
	endfunction

	// fold one accepted triangle into the tally, queue a total at mesh end
	task automatic account_triangle(input msa_pkg::tri_item_t t);
		logic [63:0]         twice;
		msa_pkg::area_item_t total;
		twice = doubled_area(t);
		if (twice > 64'(msa_pkg::SUM_MAX) - 64'(mesh_tally)) begin
			mesh_tally   = msa_pkg::SUM_MAX;
			mesh_clamped = 1'b1;
		end else begin
			mesh_tally = mesh_tally + twice[msa_pkg::SUM_W-1:0];
		end
		if (t.last_triangle) begin
			total.twice_area_total = mesh_tally;
			total.saturated        = mesh_clamped;
			pending_totals = {pending_totals, total};
			mesh_tally   = '0;
			mesh_clamped = 1'b0;
		end
	endtask

	// offer one triangle, hold it until taken, then maybe idle a while
	task automatic send_triangle(input msa_pkg::tri_item_t t);
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		account_triangle(t);
		if (!steady && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 190)) @(posedge clk);
		end
	endtask

	function automatic int extreme_coord();
		case ($urandom_range(5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic msa_pkg::tri_item_t rand_triangle(input bit last);
		int c [9];
		int k;
		case ($urandom_range(9))
			// clustered around a random corner, may wrap
			5, 6: begin
				c[0] = $urandom; c[1] = $urandom; c[2] = $urandom;
				for (int i = 3; i < 9; i++) c[i] = c[i % 3] + $urandom_range(31) - 16;
			end
			// collinear vertices
			7: begin
				for (int i = 0; i < 3; i++) begin
					c[i]     = $urandom_range(60000) - 30000;
					c[i + 3] = c[i] + $urandom_range(200) - 100;
				end
				k = $urandom_range(6) - 3;
				for (int i = 0; i < 3; i++) c[i + 6] = c[i] + k * (c[i + 3] - c[i]);
			end
			// two or three vertices coincide
			8: begin
				for (int i = 0; i < 9; i++) c[i] = $urandom;
				k = $urandom_range(2);
				for (int i = 0; i < 3; i++) begin
					if (k == 0) c[i + 3] = c[i];
					else if (k == 1) c[i + 6] = c[i];
					else begin
						c[i + 3] = c[i];
						c[i + 6] = c[i];
					end
				end
			end
			9: for (int i = 0; i < 9; i++) c[i] = extreme_coord();
			default: for (int i = 0; i < 9; i++) c[i] = $urandom;
		endcase
		return make_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], last);
	endfunction

	// whole meshes of random length with random triangles
	task automatic run_random_meshes(input int n_items, input int max_len);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 60) len = $urandom_range(1, 4);
			else if (r < 90) len = $urandom_range(5, 12);
			else len = $urandom_range(13, 40);
			if (len > max_len) len = max_len;
			for (int i = 0; i < len && sent < n_items; i++) begin
				send_triangle(rand_triangle(i == len - 1 || sent == n_items - 1));
				sent++;
			end
		end
	endtask

	// one-triangle meshes of known shape and the field extremes
	task automatic test_single_shapes();
		send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1));
		send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 1'b1));
		send_triangle(make_tri(0, 0, 0, 0, 3, 0, 0, 0, 4, 1'b1));
		send_triangle(make_tri(0, 0, 0, 5, 0, 0, 0, 0, 7, 1'b1));
		send_triangle(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1, 1'b1));
		send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
			-32768, 32767, 32767, 1'b1));
		send_triangle(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768, 1'b1));
		send_triangle(make_tri(-1, -1, -1, 0, -1, -1, -1, -1, 0, 1'b1));
	endtask

	// degenerate triangles inside a mesh, long sums, back-to-back meshes
	task automatic test_mesh_sequences();
		send_triangle(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b0));
		send_triangle(make_tri(100, -200, 300, 100, -200, 300, 100, -200, 300, 1'b0));
		send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 2, 1'b0));
		send_triangle(make_tri(0, 0, 0, 2, 0, 0, 0, 2, 0, 1'b1));
		for (int i = 0; i < 5; i++)
			send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767 - i, -32768,
				-32768, 32767, 32767, i == 4));
		send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1));
		send_triangle(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 1'b1));
		send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
	endtask

	// receiver holds off for a long stretch while triangles keep coming
	task automatic test_output_stall();
		steady   = 1'b1;
		hold_req = 1200;
		run_random_meshes(40, 2);
		steady = 1'b0;
	endtask

	// one long mesh of the largest triangle, then a small mesh after it
	task automatic test_large_mesh();
		msa_pkg::tri_item_t big;
		steady = 1'b1;
		big    = make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
			-32768, 32767, 32767, 1'b0);
		for (int i = 0; i < 30; i++) send_triangle(big);
		big.last_triangle = 1'b1;
		send_triangle(big);
		// next mesh must start from a clear sum and flag
		send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 1'b1));
		steady = 1'b0;
	endtask

	// output side: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 30);
		end
	end

	// compare each mesh total with the oldest expectation; watchdog
	always @(posedge clk) begin : check_totals
		msa_pkg::area_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_totals.size() == 0) begin
				errors++;
				$display("%0t: unexpected mesh total %0d saturated %0b", $time,
					out_data.twice_area_total, out_data.saturated);
			end else begin
				want = pending_totals.pop_front();
				if (out_data.twice_area_total !== want.twice_area_total) begin
					errors++;
					$display("%0t: twice_area_total expected %0d, got %0d", $time,
						want.twice_area_total, out_data.twice_area_total);
				end
				if (out_data.saturated !== want.saturated) begin
					errors++;
					$display("%0t: saturated expected %0b, got %0b", $time,
						want.saturated, out_data.saturated);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		mesh_tally   = '0;
		mesh_clamped = 1'b0;
		errors       = 0;
		idle_cycles  = 0;
		hold_req     = 0;
		hold_left    = 0;
		steady       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_shapes();
		test_mesh_sequences();
		run_random_meshes(600, 40);
		steady = 1'b1;
		run_random_meshes(250, 40);
		steady = 1'b0;
		test_output_stall();
		test_large_mesh();
		run_random_meshes(450, 40);

		// drain: all totals back, then a margin for strays
		in_valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/msa_pkg.sv
design/msa_ctrl.sv
design/msa_datapath.sv
design/mesh_surface_area_accumulator.sv
test/mesh_surface_area_accumulator_test.sv
